[rtl/core/lfuc_pkg.sv]
// shared types and constants for the lfu cache with lru tie break
// no dependencies; used by the interface, the scan unit, the top level and the checker
package lfuc_pkg;

   localparam int KEY_W   = 32;
   localparam int VALUE_W = 32;
   localparam int COUNT_W = 32;
   localparam int CSR_W   = 5;

   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   localparam logic signed [VALUE_W-1:0] GET_MISS_VALUE = -32'sd1;
   localparam logic [COUNT_W-1:0]        COUNT_MAX      = 32'hFFFF_FFFF;
   localparam logic [CSR_W-1:0]          CAPACITY_RESET = 5'd16;

   typedef struct packed {
      logic                      op;
      logic signed [KEY_W-1:0]   key;
      logic signed [VALUE_W-1:0] value;
   } req_payload_type;

   typedef struct packed {
      logic                      hit;
      logic signed [VALUE_W-1:0] read_value;
      logic                      evicted;
      logic signed [KEY_W-1:0]   evicted_key;
   } rsp_payload_type;

   // per-entry decisions of the scan compare unit
   typedef struct packed {
      logic match;
      logic take_victim;
      logic is_free;
   } scan_flags_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_UPDATE = 3'b100
   } state_type;

endpackage

[rtl/core/lfuc_chan_if.sv]
// valid/ready channel carrying one payload, a request payload by default
// depends on lfuc_pkg for the payload types
interface lfuc_chan_if #(
   parameter type payload_type = lfuc_pkg::req_payload_type
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[rtl/core/lfuc_scan_unit.sv]
// shared compare unit: key match, victim order and free test for one entry
// depends on lfuc_pkg
module lfuc_scan_unit #(
   parameter int RANK_W = 4
) (
   input  logic                          entry_valid,
   input  logic [lfuc_pkg::KEY_W-1:0]    entry_key,
   input  logic [lfuc_pkg::COUNT_W-1:0]  entry_count,
   input  logic [RANK_W-1:0]             entry_rank,
   input  logic [lfuc_pkg::KEY_W-1:0]    req_key,
   input  logic                          have_victim,
   input  logic [lfuc_pkg::COUNT_W-1:0]  victim_count,
   input  logic [RANK_W-1:0]             victim_rank,
   output lfuc_pkg::scan_flags_type      flags
);

   logic fewer_uses;
   logic same_uses_older;

   assign fewer_uses      = entry_count < victim_count;
   assign same_uses_older = (entry_count == victim_count) && (entry_rank > victim_rank);

   always_comb begin
      flags.match       = entry_valid && (entry_key == req_key);
      flags.take_victim = entry_valid && (!have_victim || fewer_uses || same_uses_older);
      flags.is_free     = !entry_valid;
   end

endmodule

[rtl/core/lfu_cache_lru_tiebreak.sv]
// lfu cache with lru tie break: top level, sequencer, storage and result register
// depends on lfuc_pkg, lfuc_chan_if and lfuc_scan_unit
// requests are taken only in idle, one at a time: accept, a read per entry, drain, update;
// an unclaimed result holds the next request in update until the result register frees
// reset: synchronous active high; cache empty, capacity_in_use = 16, no result pending
module lfu_cache_lru_tiebreak #(
   parameter int CAPACITY = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   lfuc_chan_if.sink                   req_if,
   lfuc_chan_if.source                 rsp_if,
   input  logic                        csr_we,
   input  logic [lfuc_pkg::CSR_W-1:0]  csr_wdata
);

   localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int RANK_W = IDX_W;
   localparam int KEY_W  = lfuc_pkg::KEY_W;
   localparam int VAL_W  = lfuc_pkg::VALUE_W;
   localparam int CNT32  = lfuc_pkg::COUNT_W;

   // sequencer and configuration
   lfuc_pkg::state_type          state_ff, state_in;
   logic [lfuc_pkg::CSR_W-1:0]   capacity_in_use_ff, capacity_in_use_in;

   // latched request
   logic                         op_ff;
   logic [KEY_W-1:0]             key_ff;
   logic [VAL_W-1:0]             value_ff;

   // scan address counter and read pipeline
   logic [CNT_W-1:0]             scan_cnt_ff, scan_cnt_in;
   logic                         rd_pend_ff, rd_pend_in;
   logic [IDX_W-1:0]             rd_idx_ff, rd_idx_in;
   logic                         rd_issue;
   logic [IDX_W-1:0]             rd_addr;

   // entry memories, read once per entry during a scan, written once per update
   logic [KEY_W-1:0]             key_mem   [CAPACITY];
   logic [VAL_W-1:0]             value_mem [CAPACITY];
   logic [CNT32-1:0]             count_mem [CAPACITY];
   logic [KEY_W-1:0]             key_rd_ff;
   logic [VAL_W-1:0]             value_rd_ff;
   logic [CNT32-1:0]             count_rd_ff;

   // per-entry cells updated in parallel
   logic                         valid_ff [CAPACITY];
   logic                         valid_in [CAPACITY];
   logic [RANK_W-1:0]            rank_ff  [CAPACITY];
   logic [RANK_W-1:0]            rank_in  [CAPACITY];
   logic [CNT_W-1:0]             occupancy_ff, occupancy_in;

   // scan results
   logic                         found_ff, found_in;
   logic [IDX_W-1:0]             found_idx_ff, found_idx_in;
   logic [VAL_W-1:0]             found_value_ff, found_value_in;
   logic [CNT32-1:0]             found_count_ff, found_count_in;
   logic [RANK_W-1:0]            found_rank_ff, found_rank_in;
   logic                         vic_ff, vic_in;
   logic [IDX_W-1:0]             vic_idx_ff, vic_idx_in;
   logic [KEY_W-1:0]             vic_key_ff, vic_key_in;
   logic [CNT32-1:0]             vic_count_ff, vic_count_in;
   logic [RANK_W-1:0]            vic_rank_ff, vic_rank_in;
   logic                         free_ff, free_in;
   logic [IDX_W-1:0]             free_idx_ff, free_idx_in;

   // result register
   logic                         rsp_valid_ff, rsp_valid_in;
   lfuc_pkg::rsp_payload_type    rsp_payload_ff, rsp_payload_in;

   // update decisions
   logic [CNT_W-1:0]             cap_eff;
   logic                         need_evict;
   logic                         evict_do;
   logic                         insert_do;
   logic [IDX_W-1:0]             slot_idx;
   logic                         commit;
   logic                         out_free;
   logic                         req_accept;
   logic [CNT32-1:0]             bumped_count;

   // write port controls
   logic                         key_we;
   logic                         value_we;
   logic                         count_we;
   logic [IDX_W-1:0]             wr_idx;
   logic [VAL_W-1:0]             value_wdata;
   logic [CNT32-1:0]             count_wdata;

   lfuc_pkg::scan_flags_type     scan_flags;

   assign req_if.ready   = (state_ff == lfuc_pkg::ST_IDLE);
   assign req_accept     = req_if.valid && req_if.ready;
   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_payload_ff;
   assign out_free       = !rsp_valid_ff || rsp_if.ready;

   // scan issues one read per cycle at the counter address
   assign rd_issue = (state_ff == lfuc_pkg::ST_SCAN) && (scan_cnt_ff < CNT_W'(CAPACITY));
   assign rd_addr  = scan_cnt_ff[IDX_W-1:0];

   // the one compare unit, fed by the registered memory read and the entry cells
   lfuc_scan_unit #(
      .RANK_W (RANK_W)
   ) u_scan (
      .entry_valid  (valid_ff[rd_idx_ff]),
      .entry_key    (key_rd_ff),
      .entry_count  (count_rd_ff),
      .entry_rank   (rank_ff[rd_idx_ff]),
      .req_key      (key_ff),
      .have_victim  (vic_ff),
      .victim_count (vic_count_ff),
      .victim_rank  (vic_rank_ff),
      .flags        (scan_flags)
   );

   // capacity clamp: zero acts as one, above CAPACITY acts as CAPACITY
   always_comb begin
      if (capacity_in_use_ff == '0) begin
         cap_eff = CNT_W'(1);
      end else if (int'(capacity_in_use_ff) > CAPACITY) begin
         cap_eff = CNT_W'(CAPACITY);
      end else begin
         cap_eff = CNT_W'(capacity_in_use_ff);
      end
   end

   assign need_evict = occupancy_ff >= cap_eff;
   assign commit     = (state_ff == lfuc_pkg::ST_UPDATE) && out_free;
   assign evict_do   = !found_ff && (op_ff == lfuc_pkg::OP_PUT) && need_evict && vic_ff;
   // new entry goes to the lowest free index, the evicted one included
   assign slot_idx   = (evict_do && !(free_ff && (free_idx_ff < vic_idx_ff))) ?
                       vic_idx_ff : free_idx_ff;
   assign insert_do  = !found_ff && (op_ff == lfuc_pkg::OP_PUT) && (evict_do || free_ff);
   assign bumped_count = (found_count_ff == lfuc_pkg::COUNT_MAX) ?
                         found_count_ff : found_count_ff + CNT32'(1);

   // memory write port: insert at slot, or count refresh on a hit and value refresh on a put hit
   always_comb begin
      key_we      = commit && insert_do;
      value_we    = commit && (insert_do || (found_ff && (op_ff == lfuc_pkg::OP_PUT)));
      count_we    = commit && (insert_do || found_ff);
      wr_idx      = found_ff ? found_idx_ff : slot_idx;
      value_wdata = value_ff;
      count_wdata = found_ff ? bumped_count : CNT32'(1);
   end

   always_ff @(posedge clock) begin
      if (rd_issue) begin
         key_rd_ff   <= key_mem[rd_addr];
         value_rd_ff <= value_mem[rd_addr];
         count_rd_ff <= count_mem[rd_addr];
      end
      if (key_we) begin
         key_mem[wr_idx] <= key_ff;
      end
      if (value_we) begin
         value_mem[wr_idx] <= value_wdata;
      end
      if (count_we) begin
         count_mem[wr_idx] <= count_wdata;
      end
   end

   // sequencer, scan bookkeeping and result
   always_comb begin
      state_in           = state_ff;
      capacity_in_use_in = capacity_in_use_ff;
      scan_cnt_in        = scan_cnt_ff;
      rd_pend_in         = rd_issue;
      rd_idx_in          = rd_addr;
      found_in           = found_ff;
      found_idx_in       = found_idx_ff;
      found_value_in     = found_value_ff;
      found_count_in     = found_count_ff;
      found_rank_in      = found_rank_ff;
      vic_in             = vic_ff;
      vic_idx_in         = vic_idx_ff;
      vic_key_in         = vic_key_ff;
      vic_count_in       = vic_count_ff;
      vic_rank_in        = vic_rank_ff;
      free_in            = free_ff;
      free_idx_in        = free_idx_ff;
      occupancy_in       = occupancy_ff;
      rsp_valid_in       = rsp_valid_ff;
      rsp_payload_in     = rsp_payload_ff;

      if (csr_we) begin
         capacity_in_use_in = csr_wdata;
      end

      // result handed off
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         lfuc_pkg::ST_IDLE: begin
            if (req_accept) begin
               scan_cnt_in = '0;
               found_in    = 1'b0;
               vic_in      = 1'b0;
               free_in     = 1'b0;
               state_in    = lfuc_pkg::ST_SCAN;
            end
         end
         lfuc_pkg::ST_SCAN: begin
            if (rd_issue) begin
               scan_cnt_in = scan_cnt_ff + CNT_W'(1);
            end
            if (rd_pend_ff) begin
               // first match wins, lowest index
               if (scan_flags.match && !found_ff) begin
                  found_in       = 1'b1;
                  found_idx_in   = rd_idx_ff;
                  found_value_in = value_rd_ff;
                  found_count_in = count_rd_ff;
                  found_rank_in  = rank_ff[rd_idx_ff];
               end
               if (scan_flags.take_victim) begin
                  vic_in       = 1'b1;
                  vic_idx_in   = rd_idx_ff;
                  vic_key_in   = key_rd_ff;
                  vic_count_in = count_rd_ff;
                  vic_rank_in  = rank_ff[rd_idx_ff];
               end
               if (scan_flags.is_free && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = rd_idx_ff;
               end
               if (rd_idx_ff == IDX_W'(CAPACITY - 1)) begin
                  state_in = lfuc_pkg::ST_UPDATE;
               end
            end
         end
         lfuc_pkg::ST_UPDATE: begin
            // waits here while an earlier result is still unclaimed
            if (commit) begin
               if (insert_do && !evict_do) begin
                  occupancy_in = occupancy_ff + CNT_W'(1);
               end
               rsp_valid_in           = 1'b1;
               rsp_payload_in.hit     = found_ff;
               rsp_payload_in.evicted = evict_do;
               rsp_payload_in.evicted_key = evict_do ? vic_key_ff : '0;
               if (op_ff == lfuc_pkg::OP_PUT) begin
                  rsp_payload_in.read_value = '0;
               end else if (found_ff) begin
                  rsp_payload_in.read_value = found_value_ff;
               end else begin
                  rsp_payload_in.read_value = lfuc_pkg::GET_MISS_VALUE;
               end
               state_in = lfuc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lfuc_pkg::ST_IDLE;
         end
      endcase
   end

   // recency cells: all entries move together, in parallel
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         valid_in[i] = valid_ff[i];
         rank_in[i]  = rank_ff[i];
         if (commit && found_ff) begin
            // hit: younger entries age by one, the hit entry becomes most recent
            if (IDX_W'(i) == found_idx_ff) begin
               rank_in[i] = '0;
            end else if (valid_ff[i] && (rank_ff[i] < found_rank_ff)) begin
               rank_in[i] = rank_ff[i] + RANK_W'(1);
            end
         end else if (commit && insert_do) begin
            if (IDX_W'(i) == slot_idx) begin
               valid_in[i] = 1'b1;
               rank_in[i]  = '0;
            end else if (evict_do && (IDX_W'(i) == vic_idx_ff)) begin
               valid_in[i] = 1'b0;
            end else if (valid_ff[i]) begin
               // eviction closes the gap and the insert opens one: older than victim stay
               if (!(evict_do && (rank_ff[i] > vic_rank_ff))) begin
                  rank_in[i] = rank_ff[i] + RANK_W'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= lfuc_pkg::ST_IDLE;
         capacity_in_use_ff <= lfuc_pkg::CAPACITY_RESET;
         rd_pend_ff         <= 1'b0;
         found_ff           <= 1'b0;
         vic_ff             <= 1'b0;
         free_ff            <= 1'b0;
         occupancy_ff       <= '0;
         rsp_valid_ff       <= 1'b0;
         for (int i = 0; i < CAPACITY; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         state_ff           <= state_in;
         capacity_in_use_ff <= capacity_in_use_in;
         rd_pend_ff         <= rd_pend_in;
         found_ff           <= found_in;
         vic_ff             <= vic_in;
         free_ff            <= free_in;
         occupancy_ff       <= occupancy_in;
         rsp_valid_ff       <= rsp_valid_in;
         for (int i = 0; i < CAPACITY; i++) begin
            valid_ff[i] <= valid_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff    <= req_if.payload.op;
         key_ff   <= req_if.payload.key;
         value_ff <= req_if.payload.value;
      end
      scan_cnt_ff    <= scan_cnt_in;
      rd_idx_ff      <= rd_idx_in;
      found_idx_ff   <= found_idx_in;
      found_value_ff <= found_value_in;
      found_count_ff <= found_count_in;
      found_rank_ff  <= found_rank_in;
      vic_idx_ff     <= vic_idx_in;
      vic_key_ff     <= vic_key_in;
      vic_count_ff   <= vic_count_in;
      vic_rank_ff    <= vic_rank_in;
      free_idx_ff    <= free_idx_in;
      rsp_payload_ff <= rsp_payload_in;
      for (int i = 0; i < CAPACITY; i++) begin
         rank_ff[i] <= rank_in[i];
      end
   end

endmodule

[rtl/core/lfuc_checker.sv]
// port-level checks for the lfu cache, bound to the top level
// depends on lfuc_pkg and lfu_cache_lru_tiebreak
module lfuc_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input lfuc_pkg::rsp_payload_type  rsp_payload
);

   // one request at a time: busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while previous one still in work");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed or dropped");

   // an eviction only comes from a put miss
   a_evict_is_put_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.evicted |-> !rsp_payload.hit && (rsp_payload.read_value == 0))
      else $error("eviction reported on a hit or a get");

   a_evict_key_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.evicted |-> rsp_payload.evicted_key == 0)
      else $error("evicted key set without eviction");

endmodule

bind lfu_cache_lru_tiebreak lfuc_checker u_lfuc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_if.valid),
   .req_ready   (req_if.ready),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .rsp_payload (rsp_if.payload)
);

[bench/lfu_cache_lru_tiebreak_test.sv]
// self-checking bench for the lfu cache with lru tie break: directed script, then random phases
// depends on lfuc_pkg, lfuc_chan_if and lfu_cache_lru_tiebreak, which needs lfuc_scan_unit
module lfu_cache_lru_tiebreak_test;

   localparam int CAPACITY        = 16;
   localparam int LATENCY         = CAPACITY + 3;
   localparam int PHASES          = 10;
   localparam int PHASE_REQUESTS  = 150;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int MAX_REPORTS     = 10;
   // worst case per request: latency plus longest sender gap plus longest receiver stall
   localparam int CYCLE_LIMIT     = 1_500_000;

   // short local names for the shared codes and types
   localparam int                         CSR_W          = lfuc_pkg::CSR_W;
   localparam logic                       OP_GET         = lfuc_pkg::OP_GET;
   localparam logic                       OP_PUT         = lfuc_pkg::OP_PUT;
   localparam logic [31:0]                GET_MISS_VALUE = lfuc_pkg::GET_MISS_VALUE;
   localparam logic [lfuc_pkg::COUNT_W-1:0] COUNT_MAX    = lfuc_pkg::COUNT_MAX;
   localparam logic [CSR_W-1:0]           CAPACITY_RESET = lfuc_pkg::CAPACITY_RESET;

   typedef lfuc_pkg::req_payload_type req_payload_type;
   typedef lfuc_pkg::rsp_payload_type rsp_payload_type;

   typedef enum logic {ROW_REQUEST, ROW_CAPACITY} row_kind_type;

   // one line of the directed script: a request, or a capacity write
   typedef struct {
      row_kind_type     kind;
      req_payload_type  req;
      logic [CSR_W-1:0] capacity;
      bit               typed;
      rsp_payload_type  rsp;
   } script_row_type;

   logic             clock;
   logic             reset;
   logic             csr_we;
   logic [CSR_W-1:0] csr_wdata;

   lfuc_chan_if #(.payload_type(req_payload_type)) req_ch ();
   lfuc_chan_if #(.payload_type(rsp_payload_type)) rsp_ch ();

   lfu_cache_lru_tiebreak #(
      .CAPACITY (CAPACITY)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch.sink),
      .rsp_if    (rsp_ch.source),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // shadow copy of the cache contents, kept in step with accepted requests
   bit               slot_used  [CAPACITY];
   logic [31:0]      slot_key   [CAPACITY];
   logic [31:0]      slot_val   [CAPACITY];
   logic [31:0]      slot_uses  [CAPACITY];
   int               slot_age   [CAPACITY];   // 0 = most recently touched
   int               fill_level;
   logic [CSR_W-1:0] capacity_setting;

   rsp_payload_type  predicted_rsp [$];
   script_row_type   script [$];

   // capacity per random phase, the last phase drawn at random; 16 -> 3 drops the limit below the
   // fill level, 0 and 31 are the clamped extremes
   logic [CSR_W-1:0] phase_caps [PHASES] =
      '{5'd16, 5'd3, 5'd1, 5'd8, 5'd0, 5'd31, 5'd2, 5'd16, 5'd5, 5'd12};

   bit sender_idles;
   bit receiver_idles;
   bit hold_off_wanted;
   bit held_off;

   int cycle_count;
   int requests_sent;
   int directed_count;
   int results_seen;
   int hits_seen;
   int evictions_seen;
   int capacity_writes;
   int mismatches;

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // gap length: mostly none or short, now and then a long one
   function automatic int idle_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 15);
      return $urandom_range(30, 90);
   endfunction

   // random 32-bit word with the extremes weighted in
   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 9))
         0: begin
            return 32'h8000_0000;
         end
         1: begin
            return 32'h7FFF_FFFF;
         end
         2: begin
            return 32'h0000_0000;
         end
         3: begin
            return 32'hFFFF_FFFF;
         end
         default: begin
            return $urandom;
         end
      endcase
   endfunction

   // predicted response of one request; updates the shadow cache
   // count saturation needs 2^32 - 1 touches of one key, far beyond this run,
   // but the shadow still stops at the ceiling
   function automatic rsp_payload_type cache_access(input req_payload_type req);
      rsp_payload_type r;
      int where;
      int victim;
      int old_age;
      int limit;
      r = '0;
      where = -1;
      for (int i = 0; i < CAPACITY; i++) begin
         if (where < 0 && slot_used[i] && slot_key[i] == req.key) where = i;
      end
      if (where >= 0) begin
         // hit: one more use, becomes most recent
         r.hit = 1'b1;
         if (slot_uses[where] != COUNT_MAX) slot_uses[where]++;
         old_age = slot_age[where];
         for (int i = 0; i < CAPACITY; i++) begin
            if (slot_used[i] && i != where && slot_age[i] < old_age) slot_age[i]++;
         end
         slot_age[where] = 0;
         if (req.op == OP_GET) r.read_value = slot_val[where];
         else slot_val[where] = req.value;
      end else if (req.op == OP_GET) begin
         r.read_value = GET_MISS_VALUE;
      end else begin
         // capacity 0 acts as 1, anything above the array size as the array size
         limit = (capacity_setting == 0) ? 1 :
                 (capacity_setting > CAPACITY) ? CAPACITY : int'(capacity_setting);
         if (fill_level >= limit) begin
            // fewest uses first, oldest among equals
            victim = -1;
            for (int i = 0; i < CAPACITY; i++) begin
               if (slot_used[i] && (victim < 0 || slot_uses[i] < slot_uses[victim] ||
                   (slot_uses[i] == slot_uses[victim] && slot_age[i] > slot_age[victim])))
                  victim = i;
            end
            if (victim >= 0) begin
               r.evicted     = 1'b1;
               r.evicted_key = slot_key[victim];
               slot_used[victim] = 1'b0;
               for (int i = 0; i < CAPACITY; i++) begin
                  if (slot_used[i] && slot_age[i] > slot_age[victim]) slot_age[i]--;
               end
               if (fill_level > 0) fill_level--;
            end
         end
         for (int i = 0; i < CAPACITY; i++) begin
            if (where < 0 && !slot_used[i]) where = i;
         end
         if (where >= 0) begin
            for (int i = 0; i < CAPACITY; i++) begin
               if (slot_used[i]) slot_age[i]++;
            end
            slot_used[where] = 1'b1;
            slot_key[where]  = req.key;
            slot_val[where]  = req.value;
            slot_uses[where] = 1;
            slot_age[where]  = 0;
            fill_level++;
         end
      end
      return r;
   endfunction

   function automatic void add_request(input logic op, input logic [31:0] key,
                                       input logic [31:0] value);
      script_row_type row;
      row = '{kind: ROW_REQUEST, req: '0, capacity: '0, typed: 1'b0, rsp: '0};
      row.req.op    = op;
      row.req.key   = key;
      row.req.value = value;
      script.push_back(row);
   endfunction

   // request whose response is plain from the script itself
   function automatic void add_checked(input logic op, input logic [31:0] key,
                                       input logic [31:0] value, input logic hit,
                                       input logic [31:0] read_value);
      add_request(op, key, value);
      script[$].typed          = 1'b1;
      script[$].rsp.hit        = hit;
      script[$].rsp.read_value = read_value;
   endfunction

   function automatic void add_capacity(input logic [CSR_W-1:0] capacity);
      script_row_type row;
      row = '{kind: ROW_CAPACITY, req: '0, capacity: capacity, typed: 1'b0, rsp: '0};
      script.push_back(row);
   endfunction

   // stop offering requests and wait until every response is back
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (predicted_rsp.size() != 0);
   endtask

   // capacity changes only with the cache idle
   task automatic write_capacity(input logic [CSR_W-1:0] capacity);
      drain_results();
      csr_we    <= 1'b1;
      csr_wdata <= capacity;
      @(negedge clock);
      csr_we <= 1'b0;
      capacity_setting = capacity;
      capacity_writes++;
   endtask

   // offer one request, called at a falling edge, returns at a falling edge
   task automatic send_request(input req_payload_type req, input bit typed,
                               input rsp_payload_type typed_rsp);
      rsp_payload_type predicted;
      int gap;
      gap = sender_idles ? idle_cycles() : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.payload <= req;
      do @(posedge clock); while (!req_ch.ready);
      // shadow always advances; scripted rows check against their typed response
      predicted = cache_access(req);
      predicted_rsp.push_back(typed ? typed_rsp : predicted);
      requests_sent++;
      @(negedge clock);
   endtask

   function automatic void note_mismatch(input string what, input rsp_payload_type want,
                                         input rsp_payload_type got);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
         $display("mismatch at cycle %0d: %s", cycle_count, what);
         $display("   expected hit=%0b read=%h evicted=%0b key=%h",
                  want.hit, want.read_value, want.evicted, want.evicted_key);
         $display("   actual   hit=%0b read=%h evicted=%0b key=%h",
                  got.hit, got.read_value, got.evicted, got.evicted_key);
      end
   endfunction

   // stimulus: reset, directed script, then random phases under varying capacity
   initial begin : stimulus
      logic [31:0]      key_pool [$];
      req_payload_type  req;
      logic [CSR_W-1:0] capacity;
      int               limit;
      int               pool_size;

      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_wdata      = '0;
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
      hold_off_wanted = 1'b0;
      fill_level     = 0;
      capacity_setting = CAPACITY_RESET;
      foreach (slot_used[i]) begin
         slot_used[i] = 1'b0;
         slot_key[i]  = '0;
         slot_val[i]  = '0;
         slot_uses[i] = '0;
         slot_age[i]  = 0;
      end
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // empty after reset: get misses, puts only fill
      add_checked(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0, GET_MISS_VALUE);
      add_checked(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 32'h0);
      add_checked(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 32'h0);
      add_checked(OP_GET, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 32'h7FFF_FFFF);
      add_checked(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 32'h8000_0000);
      // put hit replaces the value
      add_checked(OP_PUT, 32'h8000_0000, 32'h0000_0000, 1'b1, 32'h0);
      add_checked(OP_GET, 32'h8000_0000, 32'h0000_0000, 1'b1, 32'h0);
      add_checked(OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 32'h0);
      add_checked(OP_PUT, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 32'h0);
      add_checked(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'h0000_0001);
      // capacity dropped below the fill level: one eviction per put miss
      add_capacity(5'd1);
      add_request(OP_PUT, 32'h0000_1234, 32'h0000_5678);
      add_checked(OP_GET, 32'h0000_0000, 32'h0000_0000, 1'b0, GET_MISS_VALUE);
      add_request(OP_PUT, 32'h0000_4321, 32'hDEAD_BEEF);
      // zero capacity behaves as one
      add_capacity(5'd0);
      add_request(OP_PUT, 32'h0000_0055, 32'h0000_0055);
      add_request(OP_GET, 32'h0000_4321, 32'h0000_0000);
      add_request(OP_PUT, 32'h0000_0066, 32'h0000_0066);
      // above the array size clamps to the array size
      add_capacity(5'd31);
      add_request(OP_PUT, 32'h0000_0077, 32'h0000_0077);
      // equal counts: the least recent goes first
      add_capacity(5'd2);
      add_request(OP_PUT, 32'h0000_00AA, 32'h0000_000A);
      add_request(OP_PUT, 32'h0000_00BB, 32'h0000_000B);
      add_request(OP_PUT, 32'h0000_00CC, 32'h0000_000C);
      add_request(OP_GET, 32'h0000_00BB, 32'h0000_0000);
      add_request(OP_PUT, 32'h0000_00DD, 32'h0000_000D);

      foreach (script[i]) begin
         if (script[i].kind == ROW_CAPACITY) write_capacity(script[i].capacity);
         else send_request(script[i].req, script[i].typed, script[i].rsp);
      end
      directed_count = requests_sent;

      for (int p = 0; p < PHASES; p++) begin
         capacity = (p == PHASES - 1) ? 5'($urandom_range(0, 31)) : phase_caps[p];
         write_capacity(capacity);
         // some phases run without gaps on one side or the other
         sender_idles   = (p % 4 != 1);
         receiver_idles = (p % 4 != 2);
         // key pool a little larger than the capacity gives both hits and evictions
         limit = (capacity == 0) ? 1 : (capacity > CAPACITY) ? CAPACITY : int'(capacity);
         pool_size = limit + $urandom_range(1, 4);
         key_pool.delete();
         repeat (pool_size) key_pool.push_back(pick_word());
         for (int n = 0; n < PHASE_REQUESTS; n++) begin
            // long receiver hold-off while requests keep coming
            if (p == 4 && n == 5) hold_off_wanted = 1'b1;
            // one pause until the cache has answered everything
            if (p == 6 && n == 75) drain_results();
            req.op    = $urandom_range(0, 1) ? OP_PUT : OP_GET;
            req.key   = ($urandom_range(0, 9) == 0) ? pick_word()
                                                    : key_pool[$urandom_range(0, pool_size - 1)];
            req.value = pick_word();
            send_request(req, 1'b0, '0);
         end
      end

      drain_results();
      // catch any stray response after the last expected one
      repeat (LATENCY + 8) @(negedge clock);

      $display("%0d requests (%0d directed), %0d capacity writes, receiver hold-off %s",
               requests_sent, directed_count, capacity_writes, held_off ? "done" : "missed");
      $display("%0d responses checked: %0d hits, %0d evictions, %0d mismatches",
               results_seen, hits_seen, evictions_seen, mismatches);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // response ready: random stalls, plus one long hold-off on request
   initial begin : response_ready
      int stall_left;
      stall_left   = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_wanted && !held_off) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            held_off = 1'b1;
         end
         if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else if (receiver_idles && $urandom_range(0, 3) == 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left = idle_cycles();
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // response check against the oldest prediction
   always @(posedge clock) begin : response_check
      rsp_payload_type want;
      rsp_payload_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = rsp_ch.payload;
         results_seen++;
         if (got.hit) hits_seen++;
         if (got.evicted) evictions_seen++;
         if (predicted_rsp.size() == 0) begin
            note_mismatch("response with no request outstanding", '0, got);
         end else begin
            want = predicted_rsp.pop_front();
            if (got.hit !== want.hit) note_mismatch("hit differs", want, got);
            else if (got.read_value !== want.read_value)
               note_mismatch("read value differs", want, got);
            else if (got.evicted !== want.evicted) note_mismatch("evicted differs", want, got);
            else if (got.evicted_key !== want.evicted_key)
               note_mismatch("evicted key differs", want, got);
         end
      end
   end

   // run limit
   always @(posedge clock) begin : run_limit
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("cycle limit hit with %0d responses outstanding", predicted_rsp.size());
         $display("Regression FAIL");
         $finish;
      end
   end

endmodule

[sim.f]
rtl/core/lfuc_pkg.sv
rtl/core/lfuc_chan_if.sv
rtl/core/lfuc_scan_unit.sv
rtl/core/lfu_cache_lru_tiebreak.sv
rtl/core/lfuc_checker.sv
bench/lfu_cache_lru_tiebreak_test.sv
